### rtl/core/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the bitmap block allocator
// Request function codes, response status codes, the divider width and the
// status bundle that the block divider hands back to the sequencer.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Fixed header placed in front of every allocation.
  localparam int HEADER_BYTES = 4;

  // Dividend width: a 32-bit length plus the header needs one extra bit.
  localparam int DIV_W = 33;

  localparam logic [1:0] FN_ALLOC     = 2'd0;
  localparam logic [1:0] FN_FREE      = 2'd1;
  localparam logic [1:0] FN_MARK_USED = 2'd2;
  localparam logic [1:0] FN_MARK_FREE = 2'd3;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_RANGE   = 2'd2;

  typedef struct packed {
    logic             done;
    logic             rem_nz;
    logic [DIV_W-1:0] quot;
  } div_res_t;

endpackage

### rtl/core/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator: first-fit bitmap block allocator
// Keeps a used bit per block and the run length of each allocation, and
// serves allocate, free and mark requests one at a time.
// ----------------------------------------------------------------------------
// Memory from byte 0 is split into NUM_BLOCKS blocks of BLOCK_BYTES bytes;
// BLOCK_BYTES must be a power of two. After reset the block clears its used
// map, one entry at a time, and holds req_ready low meanwhile. Each request
// is then served alone by a small sequencer around one shared block-size
// shift unit and a used map walked one block per cycle. An allocate divides
// once, scans the map for a free run and then marks the blocks needed; a
// free divides once, reads the stored run length and releases the run; a
// mark does two divisions and then marks its blocks. A request rejected as
// out of range skips the scan and the marking. A finished response is held
// in an output register, so the next request is taken while the previous
// response waits; a response that finds the register still occupied stalls
// the block until it drains.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
  parameter int NUM_BLOCKS  = 1024,
  parameter int BLOCK_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  func,
  input  logic [31:0] req_length,
  input  logic [31:0] address,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [31:0] result_address,
  output logic [1:0]  status
);
  import bba_pkg::*;

  localparam int NBW = $clog2(NUM_BLOCKS);
  localparam int CW  = NBW + 1;
  localparam logic [CW-1:0]    NB_C    = CW'(NUM_BLOCKS);
  localparam logic [CW-1:0]    LAST_C  = CW'(NUM_BLOCKS - 1);
  localparam logic [DIV_W-1:0] NB_WIDE = DIV_W'(NUM_BLOCKS);
  localparam logic [31:0]      BLOCK_W = 32'(BLOCK_BYTES);

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_DIV_A   = 4'd2;
  localparam logic [3:0] ST_DIV_B   = 4'd3;
  localparam logic [3:0] ST_FREE_RD = 4'd4;
  localparam logic [3:0] ST_SCAN    = 4'd5;
  localparam logic [3:0] ST_CLIP    = 4'd6;
  localparam logic [3:0] ST_RUN     = 4'd7;
  localparam logic [3:0] ST_DONE    = 4'd8;

  logic [3:0]       state;
  logic [1:0]       op_func;
  logic [31:0]      op_len;
  logic             div_start;
  logic [DIV_W-1:0] div_in;
  div_res_t         div_res;
  logic [NBW-1:0]   start_blk;
  logic [DIV_W-1:0] cnt_wide;
  logic [CW-1:0]    need;
  logic [CW-1:0]    end_blk;
  logic [NBW-1:0]   idx;
  logic [CW-1:0]    scan_idx;
  logic [CW-1:0]    run;
  logic             rd_pend;
  logic [NBW-1:0]   rd_idx;
  logic             map_rdata;
  logic [CW-1:0]    tbl_rdata;
  logic [31:0]      res_addr;
  logic [1:0]       res_status;

  // Storage: the used map and the run length of each allocation's start.
  logic             used_map [NUM_BLOCKS];
  logic [CW-1:0]    run_len  [NUM_BLOCKS];

  logic             scan_issue;
  logic             map_we;
  logic             map_wd;
  logic             tbl_we;
  logic             tbl_re;
  logic [DIV_W-1:0] q_ceil;
  logic [CW-1:0]    run_inc;
  logic [CW-1:0]    fs_wide;
  logic [CW-1:0]    avail;
  logic [CW-1:0]    clip_cnt;
  logic [CW-1:0]    idx_inc;
  logic             run_val;

  bba_div #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_in),
    .res     (div_res)
  );

  assign req_ready = (state == ST_IDLE);

  // Ceiling of the quotient; the quotient is far below 2^32, so no overflow.
  assign q_ceil = div_res.quot + DIV_W'(div_res.rem_nz);

  // The scan reads one map entry a cycle; its data comes back through a register.
  assign scan_issue = (state == ST_SCAN) && (scan_idx < NB_C);
  assign run_inc    = run + CW'(1);
  assign fs_wide    = {1'b0, rd_idx} + CW'(1) - need;

  // A run never passes the end of the map.
  assign avail    = NB_C - {1'b0, start_blk};
  assign clip_cnt = (cnt_wide > DIV_W'(avail)) ? avail : cnt_wide[CW-1:0];
  assign idx_inc  = {1'b0, idx} + CW'(1);

  // Allocate and mark used set bits; free and mark free clear them.
  assign run_val = (op_func == FN_ALLOC) || (op_func == FN_MARK_USED);
  assign map_we  = (state == ST_CLEAR) || (state == ST_RUN);
  assign map_wd  = (state == ST_RUN) && run_val;

  assign tbl_we = (state == ST_CLIP) && (op_func == FN_ALLOC);
  assign tbl_re = (state == ST_DIV_A) && div_res.done && (op_func == FN_FREE) &&
                  (div_res.quot < NB_WIDE);

  always_ff @(posedge clk) begin
    if (map_we) begin
      used_map[idx] <= map_wd;
    end
    if (scan_issue) begin
      map_rdata <= used_map[scan_idx[NBW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      run_len[start_blk] <= need;
    end
    if (tbl_re) begin
      tbl_rdata <= run_len[div_res.quot[NBW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      idx       <= '0;
      div_start <= 1'b0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      rd_pend   <= scan_issue;
      rd_idx    <= scan_idx[NBW-1:0];
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          idx <= idx_inc[NBW-1:0];
          if ({1'b0, idx} == LAST_C) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_valid) begin
            op_func    <= func;
            op_len     <= req_length;
            res_addr   <= '0;
            res_status <= STAT_OK;
            case (func)
              FN_ALLOC: begin
                div_in    <= {1'b0, req_length} + DIV_W'(HEADER_BYTES);
                div_start <= 1'b1;
                state     <= ST_DIV_A;
              end
              FN_FREE: begin
                // An address below the header cannot belong to an allocation.
                if (address < 32'(HEADER_BYTES)) begin
                  res_status <= STAT_RANGE;
                  state      <= ST_DONE;
                end else begin
                  div_in    <= {1'b0, address - 32'(HEADER_BYTES)};
                  div_start <= 1'b1;
                  state     <= ST_DIV_A;
                end
              end
              default: begin
                div_in    <= {1'b0, address};
                div_start <= 1'b1;
                state     <= ST_DIV_A;
              end
            endcase
          end
        end
        ST_DIV_A: begin
          if (div_res.done) begin
            case (op_func)
              FN_ALLOC: begin
                if (q_ceil > NB_WIDE) begin
                  res_status <= STAT_RANGE;
                  state      <= ST_DONE;
                end else begin
                  need     <= q_ceil[CW-1:0];
                  scan_idx <= '0;
                  run      <= '0;
                  state    <= ST_SCAN;
                end
              end
              FN_FREE: begin
                if (div_res.quot >= NB_WIDE) begin
                  res_status <= STAT_RANGE;
                  state      <= ST_DONE;
                end else begin
                  start_blk <= div_res.quot[NBW-1:0];
                  state     <= ST_FREE_RD;
                end
              end
              default: begin
                if (div_res.quot >= NB_WIDE) begin
                  res_status <= STAT_RANGE;
                  state      <= ST_DONE;
                end else begin
                  start_blk <= div_res.quot[NBW-1:0];
                  div_in    <= {1'b0, op_len};
                  div_start <= 1'b1;
                  state     <= ST_DIV_B;
                end
              end
            endcase
          end
        end
        ST_DIV_B: begin
          // A zero length still covers one block.
          if (div_res.done) begin
            cnt_wide <= (q_ceil == '0) ? DIV_W'(1) : q_ceil;
            state    <= ST_CLIP;
          end
        end
        ST_FREE_RD: begin
          cnt_wide <= (tbl_rdata == '0) ? DIV_W'(1) : DIV_W'(tbl_rdata);
          state    <= ST_CLIP;
        end
        ST_SCAN: begin
          if (scan_issue) begin
            scan_idx <= scan_idx + CW'(1);
          end
          if (rd_pend) begin
            if (map_rdata) begin
              run <= '0;
            end else begin
              run <= run_inc;
            end
            if (!map_rdata && (run_inc == need)) begin
              start_blk <= fs_wide[NBW-1:0];
              cnt_wide  <= DIV_W'(need);
              state     <= ST_CLIP;
            end else if ({1'b0, rd_idx} == LAST_C) begin
              res_status <= STAT_NOSPACE;
              state      <= ST_DONE;
            end
          end
        end
        ST_CLIP: begin
          end_blk <= {1'b0, start_blk} + clip_cnt;
          idx     <= start_blk;
          if (op_func == FN_ALLOC) begin
            res_addr <= 32'(start_blk) * BLOCK_W + 32'(HEADER_BYTES);
          end
          state <= ST_RUN;
        end
        ST_RUN: begin
          idx <= idx_inc[NBW-1:0];
          if (idx_inc == end_blk) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          // Wait for the output register to be free before posting.
          if (!rsp_valid || rsp_ready) begin
            result_address <= res_addr;
            status         <= res_status;
            rsp_valid      <= 1'b1;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // The shift unit divides correctly only by a power of two.
  a_block_pow2: assert property (@(posedge clk) (BLOCK_BYTES & (BLOCK_BYTES - 1)) == 0)
    else $error("block size is not a power of two");

  // Marking never writes past the end of the run it computed.
  a_run_in_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (({1'b0, idx} < end_blk) && (end_blk <= NB_C)))
    else $error("run marking beyond its end block");

  // The divider only reports while the sequencer waits for it.
  a_div_expected: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> ((state == ST_DIV_A) || (state == ST_DIV_B)))
    else $error("divider result outside a division state");

  // A posted response carries a defined status; only a good allocate has an address.
  a_rsp_status: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ((status == STAT_OK) || (status == STAT_NOSPACE) ||
                          (status == STAT_RANGE)) &&
                         ((status == STAT_OK) || (result_address == 32'd0)))
    else $error("malformed response");
`endif

endmodule

### rtl/core/bba_div.sv
// ----------------------------------------------------------------------------
// bba_div: block-size division unit
// Divides a 33-bit byte count by the block size, a power of two, in one
// registered step, and reports the quotient and whether a remainder was left.
// ----------------------------------------------------------------------------
module bba_div #(
  parameter int BLOCK_BYTES = 4096
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [bba_pkg::DIV_W-1:0] dividend,
  output bba_pkg::div_res_t        res
);
  import bba_pkg::*;

  // The quotient is the dividend shifted down; the remainder is the bits
  // shifted out.
  localparam int SH = $clog2(BLOCK_BYTES);

  logic             done;
  logic             rem_nz;
  logic [DIV_W-1:0] quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
      if (start) begin
        quot   <= dividend >> SH;
        rem_nz <= |dividend[SH-1:0];
      end
    end
  end

  assign res.done   = done;
  assign res.rem_nz = rem_nz;
  assign res.quot   = quot;

endmodule

### test/bitmap_block_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator_tb: self-checking bench for the first-fit allocator
// Drives allocate, free and mark requests through the valid/ready request
// channel. A shadow copy of the used map and the run lengths predicts every
// reply, and each reply is checked against it in order of arrival.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_tb;
  import bba_pkg::*;

  localparam int NUM_BLOCKS      = 1024;
  localparam int BLOCK_BYTES     = 4096;
  localparam int MAP_BYTES       = NUM_BLOCKS * BLOCK_BYTES;
  localparam int RANDOM_REQUESTS = 555;
  // The slowest request is an allocate that scans the whole map and then
  // marks a long run. Even if every request took that long, and with both
  // sides stalling, the run stays far below this limit.
  localparam int CYCLE_LIMIT     = 4_000_000;
  localparam int SETTLE_CYCLES   = 200;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic [1:0]  fn;
    logic [31:0] len;
    logic [31:0] addr;
  } alloc_req_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [1:0]  stat;
  } alloc_reply_t;

  // Every input of the block is known from time zero.
  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        req_valid  = 1'b0;
  logic        req_ready;
  logic [1:0]  func       = FN_ALLOC;
  logic [31:0] req_length = '0;
  logic [31:0] address    = '0;
  logic        rsp_valid;
  logic        rsp_ready  = 1'b0;
  logic [31:0] result_address;
  logic [1:0]  status;

  // Requests waiting to be driven, and replies owed by the block.
  alloc_req_t   request_q[$];
  alloc_reply_t reply_q[$];

  // While set, neither side idles.
  bit          steady      = 1'b0;
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;

  // Shadow state of the allocator. A run length is only ever read for a
  // start block that an allocate has written, which run_written records.
  bit          shadow_used [NUM_BLOCKS];
  logic [10:0] run_blocks  [NUM_BLOCKS];
  bit          run_written [NUM_BLOCKS];
  int          written_starts[$];

  bitmap_block_allocator #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .func          (func),
    .req_length    (req_length),
    .address       (address),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .result_address(result_address),
    .status        (status)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Number of blocks that a byte length covers: anything below one block
  // still takes a whole block.
  function automatic longint unsigned blocks_spanned(longint unsigned len);
    if (len < BLOCK_BYTES) return 1;
    return (len + BLOCK_BYTES - 1) / BLOCK_BYTES;
  endfunction

  // Sets or clears a run of blocks, cut short at the end of the map. The
  // caller guarantees that the first block lies inside the map.
  function automatic void fill_blocks(longint unsigned first, longint unsigned count,
                                      bit val);
    longint unsigned b;
    if (count > NUM_BLOCKS - first) count = NUM_BLOCKS - first;
    for (b = first; b < first + count; b++) shadow_used[b] = val;
  endfunction

  // Applies one accepted request to the shadow state and queues the reply
  // that the block owes for it.
  function automatic void serve_request(alloc_req_t rq);
    alloc_reply_t    rp;
    longint unsigned need, start, run;
    bit              found;
    rp    = '{addr: '0, stat: STAT_OK};
    found = 1'b0;
    run   = 0;
    start = 0;
    case (rq.fn)
      FN_ALLOC: begin
        need = blocks_spanned(64'(rq.len) + HEADER_BYTES);
        if (need > NUM_BLOCKS) begin
          rp.stat = STAT_RANGE;
        end else begin
          // First fit: the lowest start block with enough free blocks after it.
          for (int b = 0; b < NUM_BLOCKS && !found; b++) begin
            if (shadow_used[b]) begin
              run = 0;
            end else begin
              run++;
              if (run == need) begin
                start = b + 1 - need;
                found = 1'b1;
              end
            end
          end
          if (found) begin
            fill_blocks(start, need, 1'b1);
            run_blocks[start] = 11'(need);
            if (!run_written[start]) begin
              run_written[start] = 1'b1;
              written_starts.push_back(int'(start));
            end
            rp.addr = 32'(start * BLOCK_BYTES + HEADER_BYTES);
          end else begin
            rp.stat = STAT_NOSPACE;
          end
        end
      end
      FN_FREE: begin
        if (rq.addr < HEADER_BYTES) begin
          rp.stat = STAT_RANGE;
        end else begin
          start = (64'(rq.addr) - HEADER_BYTES) / BLOCK_BYTES;
          if (start >= NUM_BLOCKS) begin
            rp.stat = STAT_RANGE;
          end else begin
            // A stored length of zero still releases one block.
            fill_blocks(start, (run_blocks[start] == 0) ? 1 : run_blocks[start], 1'b0);
          end
        end
      end
      default: begin
        // Marking works on raw block boundaries, with no header offset.
        start = 64'(rq.addr) / BLOCK_BYTES;
        if (start >= NUM_BLOCKS) begin
          rp.stat = STAT_RANGE;
        end else begin
          fill_blocks(start, blocks_spanned(64'(rq.len)), rq.fn == FN_MARK_USED);
        end
      end
    endcase
    reply_q.push_back(rp);
  endfunction

  // Keeps the pending queue short, so that random frees are chosen from
  // start blocks that earlier allocates have actually written.
  task automatic push_request(input logic [1:0] fn, input logic [31:0] len,
                              input logic [31:0] addr);
    while (request_q.size() >= 2) @(negedge clk);
    request_q.push_back('{fn: fn, len: len, addr: addr});
  endtask

  // Returns once every queued request has been taken and answered.
  task automatic wait_for_replies();
    while (request_q.size() != 0 || req_valid || reply_q.size() != 0) @(negedge clk);
  endtask

  // Request driver. A new request is only presented once the previous one
  // has been accepted, and each accepted request updates the prediction
  // with the values that were on the ports at that edge.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (req_valid) serve_request('{fn: func, len: req_length, addr: address});
      if (request_q.size() != 0 && (steady || $urandom_range(99) >= 9)) begin
        req_valid  <= 1'b1;
        func       <= request_q[0].fn;
        req_length <= request_q[0].len;
        address    <= request_q[0].addr;
        request_q.delete(0);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Reply monitor. Replies must arrive in request order, so each one is
  // compared with the oldest prediction still outstanding.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (reply_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected reply: address %h status %0d", result_address, status);
        end else if (result_address !== reply_q[0].addr || status !== reply_q[0].stat) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("reply mismatch: expected address %h status %0d, got address %h status %0d",
                     reply_q[0].addr, reply_q[0].stat, result_address, status);
        end
        if (reply_q.size() != 0) reply_q.delete(0);
      end
      rsp_ready <= steady || ($urandom_range(99) >= 9);
    end
  end

  // Watchdog against a hung block.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    alloc_req_t  rq;
    int unsigned pick, start;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. The block rounds length plus header up to whole
    // blocks, so lengths either side of a block boundary come first.
    push_request(FN_ALLOC, 32'd0, 32'd0);                          // block 0
    push_request(FN_ALLOC, BLOCK_BYTES - HEADER_BYTES - 1, 32'd0);  // block 1
    push_request(FN_ALLOC, BLOCK_BYTES - HEADER_BYTES, 32'd0);      // block 2
    push_request(FN_ALLOC, BLOCK_BYTES - HEADER_BYTES + 1, 32'd0);  // blocks 3 and 4
    push_request(FN_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);           // too large
    push_request(FN_ALLOC, MAP_BYTES - HEADER_BYTES, 32'd0);        // whole map, no room
    // Frees below the header and beyond the map are rejected.
    push_request(FN_FREE, 32'd0, 32'd0);
    push_request(FN_FREE, 32'd0, HEADER_BYTES - 1);
    push_request(FN_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_request(FN_FREE, 32'd0, MAP_BYTES + HEADER_BYTES);
    // Proper frees, the second from the far end of its start block.
    push_request(FN_FREE, 32'd0, HEADER_BYTES);
    push_request(FN_FREE, 32'd0, 3 * BLOCK_BYTES + HEADER_BYTES + BLOCK_BYTES - 1);
    // Marks starting beyond the map are rejected.
    push_request(FN_MARK_USED, 32'd0, 32'hFFFF_FFFF);
    push_request(FN_MARK_FREE, 32'd1, MAP_BYTES);
    // A huge mark on the last block is clipped at the end of the map.
    push_request(FN_MARK_USED, 32'hFFFF_FFFF, MAP_BYTES - 1);
    push_request(FN_ALLOC, 32'd0, 32'd0);
    push_request(FN_MARK_FREE, 32'hFFFF_FFFF, 32'd0);
    // The largest allocate that fits fills the map exactly.
    push_request(FN_ALLOC, MAP_BYTES - HEADER_BYTES, 32'd0);
    push_request(FN_ALLOC, 32'd0, 32'd0);
    push_request(FN_MARK_FREE, 32'd0, 32'd7);
    push_request(FN_ALLOC, 32'd0, 32'd0);
    push_request(FN_ALLOC, MAP_BYTES - HEADER_BYTES + 1, 32'd0);
    // Upper half used: one block too many finds no run, exactly half fits.
    push_request(FN_MARK_FREE, 32'hFFFF_FFFF, 32'd0);
    push_request(FN_MARK_USED, MAP_BYTES / 2, MAP_BYTES / 2);
    push_request(FN_ALLOC, MAP_BYTES / 2 - HEADER_BYTES + 1, 32'd0);
    push_request(FN_ALLOC, MAP_BYTES / 2 - HEADER_BYTES, 32'd0);
    push_request(FN_FREE, 32'd0, HEADER_BYTES);
    wait_for_replies();

    // Random part. Most requests are allocates of modest size and frees of
    // runs that were really allocated; marks stir the map up and down, and
    // some requests carry arbitrary 32-bit values.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      steady = (n >= 250 && n < 350);
      // Now and then let the block run completely dry.
      if (n == 200 || n == 400) wait_for_replies();
      pick    = $urandom_range(99);
      rq.len  = $urandom;
      rq.addr = $urandom;
      if (pick < 40) begin
        rq.fn = FN_ALLOC;
        case ($urandom_range(9))
          0: ;  // arbitrary length, nearly always too large
          1: rq.len = $urandom_range(MAP_BYTES - HEADER_BYTES, MAP_BYTES - 40 * BLOCK_BYTES);
          2, 3: rq.len = $urandom_range(64 * BLOCK_BYTES);
          default: rq.len = $urandom_range(4 * BLOCK_BYTES);
        endcase
      end else if (pick < 70) begin
        rq.fn = FN_FREE;
        if (written_starts.size() != 0 && $urandom_range(99) < 85) begin
          start   = written_starts[$urandom_range(written_starts.size() - 1)];
          rq.addr = start * BLOCK_BYTES + HEADER_BYTES + $urandom_range(BLOCK_BYTES - 1);
        end else if (rq.addr >= HEADER_BYTES) begin
          // An arbitrary address must not land on a start block whose run
          // length has never been written; such a free is pushed below
          // the header instead.
          start = (rq.addr - HEADER_BYTES) / BLOCK_BYTES;
          if (start < NUM_BLOCKS && !run_written[start])
            rq.addr = $urandom_range(HEADER_BYTES - 1);
        end
      end else begin
        rq.fn = (pick < 85) ? FN_MARK_USED : FN_MARK_FREE;
        if ($urandom_range(4) != 0) rq.addr = $urandom_range(MAP_BYTES - 1);
        case ($urandom_range(9))
          0: ;
          1: rq.len = $urandom_range(MAP_BYTES);
          default: rq.len = $urandom_range(16 * BLOCK_BYTES);
        endcase
      end
      push_request(rq.fn, rq.len, rq.addr);
    end
    steady = 1'b0;

    wait_for_replies();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
